// File: rtl/core/tpi_pkg.sv
// package for the triangle / plane crossing core
// types, widths and divider step shared by the core and its lane module
// no dependencies
package tpi_pkg;

    // coordinate and distance widths
    localparam int COORD_W = 32;
    localparam int NRM_W   = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = DIFF_W + NRM_W;
    localparam int DIST_W  = PROD_W + 2;
    localparam int REM_W   = DIST_W;
    localparam int FRAC_W  = 32;

    // fraction divider layout
    localparam int DIV_STEP   = 2;
    localparam int DIV_STAGES = FRAC_W / DIV_STEP;
    localparam int LANE_LAT   = DIV_STAGES + 2;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NORMAL_X = 3'd0,
        CFG_NORMAL_Y = 3'd1,
        CFG_NORMAL_Z = 3'd2,
        CFG_ORIGIN_X = 3'd3,
        CFG_ORIGIN_Y = 3'd4,
        CFG_ORIGIN_Z = 3'd5
    } t_cfg_idx;

    localparam logic signed [NRM_W-1:0] NORMAL_Z_RST = 16'sd32767;

    // input item
    typedef struct packed {
        logic signed [COORD_W-1:0] vertex_a_x;
        logic signed [COORD_W-1:0] vertex_a_y;
        logic signed [COORD_W-1:0] vertex_a_z;
        logic signed [COORD_W-1:0] vertex_b_x;
        logic signed [COORD_W-1:0] vertex_b_y;
        logic signed [COORD_W-1:0] vertex_b_z;
        logic signed [COORD_W-1:0] vertex_c_x;
        logic signed [COORD_W-1:0] vertex_c_y;
        logic signed [COORD_W-1:0] vertex_c_z;
        logic                      last_triangle;
    } t_tri_in;

    // result item
    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic                      last_of_item;
        logic                      slice_end;
    } t_pt_out;

    // one restoring division step: {quotient bit, new remainder}
    function automatic logic [REM_W:0] div_step(input logic [REM_W-1:0] rem,
                                                input logic [REM_W-1:0] den);
        logic [REM_W:0] sh;
        logic [REM_W:0] sub;
        sh  = {rem, 1'b0};
        sub = sh - {1'b0, den};
        if (sh >= {1'b0, den}) begin
            return {1'b1, sub[REM_W-1:0]};
        end
        return {1'b0, sh[REM_W-1:0]};
    endfunction

endpackage

// File: rtl/core/tpi_lerp_lane.sv
// one interpolation lane: pipelined fraction divider, multiply, round and offset
// depends on tpi_pkg
module tpi_lerp_lane import tpi_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [2:0][COORD_W-1:0]      i_p,
    input  logic [2:0][COORD_W-1:0]      i_mag,
    input  logic [2:0]                   i_neg,
    input  logic [REM_W-1:0]             i_num,
    input  logic [REM_W-1:0]             i_den,
    output logic [2:0][COORD_W-1:0]      o_pt
);

    logic [REM_W-1:0]          r_rem [DIV_STAGES];
    logic [REM_W-1:0]          r_den [DIV_STAGES];
    logic [FRAC_W-1:0]         r_quo [DIV_STAGES];
    logic [2:0][COORD_W-1:0]   r_p   [DIV_STAGES];
    logic [2:0][COORD_W-1:0]   r_mag [DIV_STAGES];
    logic [2:0]                r_neg [DIV_STAGES];

    // divider stages, DIV_STEP (two) quotient bits each
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        logic [REM_W-1:0]        w_rem_in;
        logic [REM_W-1:0]        w_den_in;
        logic [FRAC_W-1:0]       w_quo_in;
        logic [2:0][COORD_W-1:0] w_p_in;
        logic [2:0][COORD_W-1:0] w_mag_in;
        logic [2:0]              w_neg_in;
        logic [REM_W-1:0]        n_rem;
        logic [FRAC_W-1:0]       n_quo;

        if (k == 0) begin : g_first
            assign w_rem_in = i_num;
            assign w_den_in = i_den;
            assign w_quo_in = '0;
            assign w_p_in   = i_p;
            assign w_mag_in = i_mag;
            assign w_neg_in = i_neg;
        end else begin : g_next
            assign w_rem_in = r_rem[k-1];
            assign w_den_in = r_den[k-1];
            assign w_quo_in = r_quo[k-1];
            assign w_p_in   = r_p[k-1];
            assign w_mag_in = r_mag[k-1];
            assign w_neg_in = r_neg[k-1];
        end

        always_comb begin
            logic [REM_W:0] res;
            n_rem = w_rem_in;
            n_quo = w_quo_in;
            for (int b = 0; b < DIV_STEP; b++) begin
                res   = div_step(n_rem, w_den_in);
                n_rem = res[REM_W-1:0];
                n_quo = {n_quo[FRAC_W-2:0], res[REM_W]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_den[k] <= w_den_in;
                r_quo[k] <= n_quo;
                r_p[k]   <= w_p_in;
                r_mag[k] <= w_mag_in;
                r_neg[k] <= w_neg_in;
            end
        end
    end

    // offset magnitude products
    logic [2:0][2*COORD_W-1:0] r_prod;
    logic [2:0][COORD_W-1:0]   r_pm;
    logic [2:0]                r_ngm;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 3; j++) begin
                r_prod[j] <= (2*COORD_W)'(r_mag[DIV_STAGES-1][j])
                           * (2*COORD_W)'(r_quo[DIV_STAGES-1]);
            end
            r_pm  <= r_p[DIV_STAGES-1];
            r_ngm <= r_neg[DIV_STAGES-1];
        end
    end

    // round half up, then step from the edge start toward its end
    logic [2:0][2*COORD_W:0] w_rnd;
    logic [2:0][COORD_W-1:0] n_pt;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_rnd[j] = (2*COORD_W+1)'(r_prod[j]) + ((2*COORD_W+1)'(1) << (COORD_W-1));
            n_pt[j]  = r_ngm[j] ? r_pm[j] - w_rnd[j][2*COORD_W-1:COORD_W]
                                : r_pm[j] + w_rnd[j][2*COORD_W-1:COORD_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_pt <= n_pt;
        end
    end

endmodule

// File: rtl/core/triangle_plane_intersection_core.sv
// throughput: one triangle per cycle with up to one crossing if i_ready holds;
// one with two crossings may stall the pipe while its first point is sent; the single
// result port sets the rate, the lanes take one item a cycle unless w_en stalls them
// reset: valid bits and the point count clear, plane registers return to normal
// (0, 0, 32767) and origin (0, 0, 0); depends on tpi_pkg and tpi_lerp_lane
module triangle_plane_intersection_core import tpi_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  t_tri_in                i_tri,
    output logic                   o_valid,
    input  logic                   i_ready,
    output t_pt_out                o_pt,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [COORD_W-1:0]     i_cfg_data
);

    // plane registers
    logic signed [NRM_W-1:0]   r_nrm [3];
    logic signed [COORD_W-1:0] r_org [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nrm[0] <= '0;
            r_nrm[1] <= '0;
            r_nrm[2] <= NORMAL_Z_RST;
            r_org[0] <= '0;
            r_org[1] <= '0;
            r_org[2] <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_NORMAL_X: r_nrm[0] <= i_cfg_data[NRM_W-1:0];
                CFG_NORMAL_Y: r_nrm[1] <= i_cfg_data[NRM_W-1:0];
                CFG_NORMAL_Z: r_nrm[2] <= i_cfg_data[NRM_W-1:0];
                CFG_ORIGIN_X: r_org[0] <= i_cfg_data;
                CFG_ORIGIN_Y: r_org[1] <= i_cfg_data;
                CFG_ORIGIN_Z: r_org[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline advance
    logic w_en;
    logic w_load_ok;
    logic r_sb_vld [LANE_LAT];

    assign w_en    = !r_sb_vld[LANE_LAT-1] || w_load_ok;
    assign o_ready = w_en;

    // vertex unpack
    logic signed [COORD_W-1:0] w_v [3][3];
    assign w_v[0][0] = i_tri.vertex_a_x;
    assign w_v[0][1] = i_tri.vertex_a_y;
    assign w_v[0][2] = i_tri.vertex_a_z;
    assign w_v[1][0] = i_tri.vertex_b_x;
    assign w_v[1][1] = i_tri.vertex_b_y;
    assign w_v[1][2] = i_tri.vertex_b_z;
    assign w_v[2][0] = i_tri.vertex_c_x;
    assign w_v[2][1] = i_tri.vertex_c_y;
    assign w_v[2][2] = i_tri.vertex_c_z;

    // stage 1: offsets from origin and edge deltas
    logic                      r1_vld, r1_last;
    logic signed [DIFF_W-1:0]  r1_dv [3][3];
    logic signed [DIFF_W-1:0]  r1_e  [3][3];
    logic signed [COORD_W-1:0] r1_v  [3][3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_last <= i_tri.last_triangle;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r1_dv[i][j] <= DIFF_W'(w_v[i][j]) - DIFF_W'(r_org[j]);
                    r1_e[i][j]  <= DIFF_W'(w_v[(i == 2) ? 0 : i + 1][j])
                                 - DIFF_W'(w_v[i][j]);
                    r1_v[i][j]  <= w_v[i][j];
                end
            end
        end
    end

    // stage 2: normal products, edge magnitudes
    logic                      r2_vld, r2_last;
    logic signed [PROD_W-1:0]  r2_prod [3][3];
    logic [COORD_W-1:0]        r2_mag  [3][3];
    logic                      r2_neg  [3][3];
    logic signed [COORD_W-1:0] r2_v    [3][3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (w_en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_last <= r1_last;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r2_prod[i][j] <= PROD_W'(r1_dv[i][j]) * PROD_W'(r_nrm[j]);
                    r2_mag[i][j]  <= r1_e[i][j][DIFF_W-1] ? COORD_W'(-r1_e[i][j])
                                                          : COORD_W'(r1_e[i][j]);
                    r2_neg[i][j]  <= r1_e[i][j][DIFF_W-1];
                    r2_v[i][j]    <= r1_v[i][j];
                end
            end
        end
    end

    // stage 3: signed distances
    logic                      r3_vld, r3_last;
    logic signed [DIST_W-1:0]  r3_d   [3];
    logic [COORD_W-1:0]        r3_mag [3][3];
    logic                      r3_neg [3][3];
    logic signed [COORD_W-1:0] r3_v   [3][3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (w_en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_last <= r2_last;
            r3_mag  <= r2_mag;
            r3_neg  <= r2_neg;
            r3_v    <= r2_v;
            for (int i = 0; i < 3; i++) begin
                r3_d[i] <= DIST_W'(r2_prod[i][0]) + DIST_W'(r2_prod[i][1])
                         + DIST_W'(r2_prod[i][2]);
            end
        end
    end

    // stage 4: crossing edges, pick up to two, divider operands
    logic [2:0]             w_pos, w_ngv, w_cr;
    logic [REM_W-1:0]       w_dmag [3];
    logic [1:0]             w_e [2];
    logic [1:0]             w_n;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_ngv[i]  = r3_d[i][DIST_W-1];
            w_pos[i]  = !r3_d[i][DIST_W-1] && (r3_d[i] != '0);
            w_dmag[i] = w_ngv[i] ? REM_W'(-r3_d[i]) : REM_W'(r3_d[i]);
        end
        for (int i = 0; i < 3; i++) begin
            w_cr[i] = (w_pos[i] && w_ngv[(i == 2) ? 0 : i + 1])
                   || (w_ngv[i] && w_pos[(i == 2) ? 0 : i + 1]);
        end
        w_n = 2'(w_cr[0]) + 2'(w_cr[1]) + 2'(w_cr[2]);
        priority if (w_cr[0]) begin
            w_e[0] = 2'd0;
        end else if (w_cr[1]) begin
            w_e[0] = 2'd1;
        end else begin
            w_e[0] = 2'd2;
        end
        priority if (w_cr[0] && w_cr[1]) begin
            w_e[1] = 2'd1;
        end else begin
            w_e[1] = 2'd2;
        end
    end

    logic                    r4_vld, r4_last;
    logic [1:0]              r4_n;
    logic [2:0][COORD_W-1:0] r4_p   [2];
    logic [2:0][COORD_W-1:0] r4_mag [2];
    logic [2:0]              r4_neg [2];
    logic [REM_W-1:0]        r4_num [2];
    logic [REM_W-1:0]        r4_den [2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (w_en) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_last <= r3_last;
            r4_n    <= w_n;
            for (int l = 0; l < 2; l++) begin
                for (int j = 0; j < 3; j++) begin
                    r4_p[l][j]   <= r3_v[w_e[l]][j];
                    r4_mag[l][j] <= r3_mag[w_e[l]][j];
                    r4_neg[l][j] <= r3_neg[w_e[l]][j];
                end
                r4_num[l] <= w_dmag[w_e[l]];
                r4_den[l] <= w_dmag[w_e[l]]
                           + w_dmag[(w_e[l] == 2'd2) ? 2'd0 : w_e[l] + 2'd1];
            end
        end
    end

    // interpolation lanes
    logic [2:0][COORD_W-1:0] w_lane_pt [2];

    for (genvar l = 0; l < 2; l++) begin : g_lane
        tpi_lerp_lane u_lane (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_p   (r4_p[l]),
            .i_mag (r4_mag[l]),
            .i_neg (r4_neg[l]),
            .i_num (r4_num[l]),
            .i_den (r4_den[l]),
            .o_pt  (w_lane_pt[l])
        );
    end

    // sideband travelling alongside the lanes
    logic [1:0] r_sb_n    [LANE_LAT];
    logic       r_sb_last [LANE_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LANE_LAT; k++) begin
                r_sb_vld[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_sb_vld[0] <= r4_vld;
            for (int k = 1; k < LANE_LAT; k++) begin
                r_sb_vld[k] <= r_sb_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sb_n[0]    <= r4_n;
            r_sb_last[0] <= r4_last;
            for (int k = 1; k < LANE_LAT; k++) begin
                r_sb_n[k]    <= r_sb_n[k-1];
                r_sb_last[k] <= r_sb_last[k-1];
            end
        end
    end

    // point buffer, drains one transfer per cycle while the receiver is ready
    t_pt_out    r_slot [2];
    logic [1:0] r_cnt;
    logic       w_load;
    logic       w_pop;
    t_pt_out    w_pt0, w_pt1;

    assign w_load_ok = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_ready);
    assign w_load    = r_sb_vld[LANE_LAT-1] && w_load_ok;
    assign w_pop     = o_valid && i_ready;
    assign o_valid   = (r_cnt != 2'd0);
    assign o_pt      = r_slot[0];

    always_comb begin
        w_pt0.point_x      = w_lane_pt[0][0];
        w_pt0.point_y      = w_lane_pt[0][1];
        w_pt0.point_z      = w_lane_pt[0][2];
        w_pt0.last_of_item = (r_sb_n[LANE_LAT-1] == 2'd1);
        w_pt0.slice_end    = r_sb_last[LANE_LAT-1];
        w_pt1.point_x      = w_lane_pt[1][0];
        w_pt1.point_y      = w_lane_pt[1][1];
        w_pt1.point_z      = w_lane_pt[1][2];
        w_pt1.last_of_item = 1'b1;
        w_pt1.slice_end    = r_sb_last[LANE_LAT-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (w_load) begin
            r_cnt <= r_sb_n[LANE_LAT-1];
        end else if (w_pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_slot[0] <= w_pt0;
            r_slot[1] <= w_pt1;
        end else if (w_pop) begin
            r_slot[0] <= r_slot[1];
        end
    end

endmodule

// File: bench/triangle_plane_intersection_core_tb.sv
// testbench for triangle_plane_intersection_core: directed and random triangles
// checked against a local crossing-point predictor; depends on tpi_pkg and the core
`timescale 1ns / 100ps

module triangle_plane_intersection_core_tb;
    import tpi_pkg::*;

    localparam int  ITEMS_RANDOM = 1780;
    localparam int  DRAIN_WAIT   = 40;
    localparam int  CYCLE_LIMIT  = 2000000;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd6;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    t_tri_in              i_tri;
    logic                 o_valid;
    logic                 i_ready;
    t_pt_out              o_pt;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [COORD_W-1:0]   i_cfg_data;

    // plane copy kept by the predictor
    logic signed [NRM_W-1:0]   pl_nx, pl_ny, pl_nz;
    logic signed [COORD_W-1:0] pl_ox, pl_oy, pl_oz;

    t_pt_out exp_points[$];
    int      err_cnt;
    int      cycle_cnt;
    int      hold_off;
    bit      no_idle;

    triangle_plane_intersection_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_tri      (i_tri),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_pt       (o_pt),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // gap length: mostly short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle) return 0;
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // floor(num * 2^32 / den), num < den
    function automatic bit [63:0] frac_q32(bit [63:0] num, bit [63:0] den);
        bit [63:0] r;
        bit [63:0] q;
        r = num;
        q = 0;
        for (int i = 0; i < 32; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic bit [63:0] abs64(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // signed distance of one vertex to the plane
    function automatic longint plane_dist(longint vx, longint vy, longint vz);
        return longint'(pl_nx) * (vx - longint'(pl_ox))
             + longint'(pl_ny) * (vy - longint'(pl_oy))
             + longint'(pl_nz) * (vz - longint'(pl_oz));
    endfunction

    // expected crossing points of one triangle
    task automatic predict_crossings(t_tri_in tr);
        longint    vtx[3][3];
        longint    vd[3];
        t_pt_out   pts[2];
        int        n;
        int        nx;
        bit [63:0] t, off;
        longint    diff;
        longint    res;
        n = 0;
        vtx[0] = '{longint'(tr.vertex_a_x), longint'(tr.vertex_a_y), longint'(tr.vertex_a_z)};
        vtx[1] = '{longint'(tr.vertex_b_x), longint'(tr.vertex_b_y), longint'(tr.vertex_b_z)};
        vtx[2] = '{longint'(tr.vertex_c_x), longint'(tr.vertex_c_y), longint'(tr.vertex_c_z)};
        for (int i = 0; i < 3; i++)
            vd[i] = plane_dist(vtx[i][0], vtx[i][1], vtx[i][2]);
        for (int i = 0; i < 3; i++) begin
            nx = (i + 1) % 3;
            if (n < 2 && ((vd[i] > 0 && vd[nx] < 0) || (vd[i] < 0 && vd[nx] > 0))) begin
                t = frac_q32(abs64(vd[i]), abs64(vd[i]) + abs64(vd[nx]));
                for (int k = 0; k < 3; k++) begin
                    diff = vtx[nx][k] - vtx[i][k];
                    off  = (abs64(diff) * t + 64'h8000_0000) >> 32;
                    res  = (diff < 0) ? vtx[i][k] - longint'(off) : vtx[i][k] + longint'(off);
                    case (k)
                        0: pts[n].point_x = res[31:0];
                        1: pts[n].point_y = res[31:0];
                        default: pts[n].point_z = res[31:0];
                    endcase
                end
                pts[n].last_of_item = 1'b0;
                pts[n].slice_end    = tr.last_triangle;
                n++;
            end
        end
        if (n > 0) pts[n-1].last_of_item = 1'b1;
        for (int i = 0; i < n; i++) exp_points.insert(exp_points.size(), pts[i]);
    endtask

    // one triangle transfer; valid is left high for a back-to-back follower
    task automatic send_tri(t_tri_in tr);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_tri   = tr;
        i_valid = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        predict_crossings(tr);
        @(negedge i_clk);
    endtask

    // wait until every expected point is out and the pipe is quiet
    task automatic drain();
        i_valid = 1'b0;
        while (exp_points.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        case (idx)
            CFG_NORMAL_X: pl_nx = data[NRM_W-1:0];
            CFG_NORMAL_Y: pl_ny = data[NRM_W-1:0];
            CFG_NORMAL_Z: pl_nz = data[NRM_W-1:0];
            CFG_ORIGIN_X: pl_ox = data;
            CFG_ORIGIN_Y: pl_oy = data;
            CFG_ORIGIN_Z: pl_oz = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_plane(logic [15:0] nx, logic [15:0] ny, logic [15:0] nz,
                             logic [31:0] ox, logic [31:0] oy, logic [31:0] oz);
        cfg_write(CFG_NORMAL_X, {16'h0, nx});
        cfg_write(CFG_NORMAL_Y, {16'h0, ny});
        cfg_write(CFG_NORMAL_Z, {16'h0, nz});
        cfg_write(CFG_ORIGIN_X, ox);
        cfg_write(CFG_ORIGIN_Y, oy);
        cfg_write(CFG_ORIGIN_Z, oz);
    endtask

    function automatic t_tri_in make_tri(logic [31:0] ax, ay, az, bx, by, bz,
                                         cx, cy, cz, logic lt);
        t_tri_in tr;
        tr = '{ax, ay, az, bx, by, bz, cx, cy, cz, lt};
        return tr;
    endfunction

    // coordinate: fully random, or near the plane origin
    function automatic logic [31:0] rand_coord(logic [31:0] center);
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return center + 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
            2: return center + 32'($signed($urandom_range(0, 32'h1000)) - 32'sh800);
            default: return center + ($urandom >> $urandom_range(1, 12))
                          - ($urandom >> $urandom_range(1, 12));
        endcase
    endfunction

    function automatic t_tri_in rand_tri();
        return make_tri(rand_coord(pl_ox), rand_coord(pl_oy), rand_coord(pl_oz),
                        rand_coord(pl_ox), rand_coord(pl_oy), rand_coord(pl_oz),
                        rand_coord(pl_ox), rand_coord(pl_oy), rand_coord(pl_oz),
                        1'($urandom));
    endfunction

    // result check on every accepted transfer
    always @(posedge i_clk) begin
        t_pt_out exp_pt;
        if (i_rst_n && o_valid && i_ready) begin
            if (exp_points.size() == 0) begin
                $error("unexpected point x=%h y=%h z=%h", o_pt.point_x, o_pt.point_y,
                       o_pt.point_z);
                err_cnt++;
            end else begin
                exp_pt = exp_points.pop_front();
                if (o_pt.point_x !== exp_pt.point_x) begin
                    $error("point_x exp %h got %h", exp_pt.point_x, o_pt.point_x);
                    err_cnt++;
                end
                if (o_pt.point_y !== exp_pt.point_y) begin
                    $error("point_y exp %h got %h", exp_pt.point_y, o_pt.point_y);
                    err_cnt++;
                end
                if (o_pt.point_z !== exp_pt.point_z) begin
                    $error("point_z exp %h got %h", exp_pt.point_z, o_pt.point_z);
                    err_cnt++;
                end
                if (o_pt.last_of_item !== exp_pt.last_of_item) begin
                    $error("last_of_item exp %b got %b", exp_pt.last_of_item,
                           o_pt.last_of_item);
                    err_cnt++;
                end
                if (o_pt.slice_end !== exp_pt.slice_end) begin
                    $error("slice_end exp %b got %b", exp_pt.slice_end, o_pt.slice_end);
                    err_cnt++;
                end
            end
        end
    end

    // receiver ready: random stalls, long hold-off on request
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off > 0) begin
                i_ready  = 1'b0;
                hold_off = hold_off - 1;
            end else if (no_idle) begin
                i_ready = 1'b1;
            end else begin
                case ($urandom_range(0, 99)) inside
                    [0:59]:  i_ready = 1'b1;
                    [60:96]: i_ready = 1'b0;
                    default: begin
                        i_ready = 1'b0;
                        repeat ($urandom_range(15, 50)) @(negedge i_clk);
                    end
                endcase
            end
        end
    end

    // default plane after reset: z = 0 slicing
    task automatic test_reset_plane();
        send_tri(make_tri(0, 0, 32'hFFFF_0000, 0, 0, 32'h0001_0000, 0, 0, 0, 1'b0));
        send_tri(make_tri(32'h0002_0000, 0, 32'h0003_0000, 0, 32'h0005_0000,
                          32'hFFFD_0000, 32'h0001_0000, 0, 32'h0001_0000, 1'b1));
        drain();
    endtask

    // coordinate extremes, vertex on plane, no crossing, both end marks
    task automatic test_directed_cases();
        set_plane(16'h0000, 16'h0000, 16'h7FFF, 0, 0, 0);
        send_tri(make_tri(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                          32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1));
        send_tri(make_tri(32'hFFFF_FFFF, 0, 32'h7FFF_FFFF, 1, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF, 0, 0, 32'h8000_0000, 1'b0));
        // vertex a on plane
        send_tri(make_tri(5, 5, 0, 7, 7, 32'h0001_0000, 9, 9, 32'hFFFF_0000, 1'b1));
        // all above: no points, end mark dropped
        send_tri(make_tri(1, 2, 3, 4, 5, 6, 7, 8, 9, 1'b1));
        // two vertices on plane
        send_tri(make_tri(1, 2, 0, 4, 5, 0, 7, 8, 32'h1234, 1'b0));
        drain();
        set_plane(16'h8000, 16'h8000, 16'h8000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_tri(make_tri(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1));
        send_tri(make_tri(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                          32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          0, 0, 0, 1'b0));
        drain();
        set_plane(16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_tri(make_tri(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                          32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1));
        drain();
        // zero normal never crosses; unused index is ignored
        set_plane(16'h0000, 16'h0000, 16'h0000, 0, 0, 0);
        cfg_write(CFG_IDX_UNUSED, 32'hFFFF_FFFF);
        send_tri(make_tri(32'h8000_0000, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0,
                          32'h7FFF_FFFF, 0, 1, 2, 1'b1));
        drain();
    endtask

    // random triangles over several random planes
    task automatic test_random_planes();
        int n_phase;
        int per;
        n_phase = 8;
        per = ITEMS_RANDOM / n_phase;
        for (int p = 0; p < n_phase; p++) begin
            if (p == 0) begin
                set_plane(16'h7FFF, 16'h8000, 16'h0001, $urandom, $urandom, $urandom);
            end else begin
                set_plane(16'($urandom), 16'($urandom), 16'($urandom), $urandom,
                          $urandom, $urandom);
                if (p % 3 == 0) cfg_write(CFG_NORMAL_X, 32'h0);
            end
            no_idle = (p == 2);
            for (int i = 0; i < per; i++) send_tri(rand_tri());
            no_idle = 1'b0;
            drain();
        end
    endtask

    // receiver holds off while triangles keep coming
    task automatic test_backpressure();
        set_plane(16'h0000, 16'h0000, 16'h7FFF, 0, 0, 0);
        hold_off = 300;
        no_idle  = 1'b1;
        for (int i = 0; i < 60; i++)
            send_tri(make_tri($urandom, $urandom, 32'h0001_0000 + ($urandom >> 4),
                              $urandom, $urandom, 32'hFFFF_0000 - ($urandom >> 4),
                              $urandom, $urandom, $urandom, 1'($urandom)));
        no_idle = 1'b0;
        drain();
    endtask

    initial begin
        err_cnt    = 0;
        cycle_cnt  = 0;
        hold_off   = 0;
        no_idle    = 1'b0;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_tri      = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_NORMAL_X;
        i_cfg_data = '0;
        pl_nx = 0;
        pl_ny = 0;
        pl_nz = NORMAL_Z_RST;
        pl_ox = 0;
        pl_oy = 0;
        pl_oz = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_reset_plane();
        test_directed_cases();
        test_backpressure();
        test_random_planes();

        if (err_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
